FILE: design/nssc_pkg.sv
// shared types and constants for the nearest scale span coordinate generator
`timescale 1ns / 1ps

package nssc_pkg;

   localparam int MAX_SPAN_DEF   = 64;
   localparam int COORD_BITS_DEF = 12;

   // payload widths fixed by the interface
   localparam int OUT_W      = 25;
   localparam int LEN_W      = 7;
   localparam int COORD_IN_W = 16;
   localparam int REQ_W      = 40;
   localparam int RSP_W      = 56;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // running column: 16 bit difference plus span offset, signed
   localparam int XW = 18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_START_X  = 3'd2,
      CSR_START_Y  = 3'd3,
      CSR_DEST_W   = 3'd4,
      CSR_DEST_H   = 3'd5,
      CSR_SRC_W    = 3'd6,
      CSR_SRC_H    = 3'd7
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_GO,
      ST_ROW_WAIT,
      ST_PIX,
      ST_COL_WAIT,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: design/nssc_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module nssc_div #(
   parameter int COORD_BITS = nssc_pkg::COORD_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [2*COORD_BITS:0]      dividend,
   input  logic [COORD_BITS-1:0]      divisor,
   output logic [nssc_pkg::OUT_W-1:0] quotient,
   output nssc_pkg::div_stat_type     stat
);

   localparam int PW = 2 * COORD_BITS + 1;
   localparam int CW = $clog2(PW);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [PW-1:0]         quo_ff, quo_in;
   logic [COORD_BITS-1:0] dsr_ff, dsr_in;

   logic [COORD_BITS:0]   trial;
   logic [COORD_BITS:0]   diff;
   logic                  ge;

   always_comb begin
      trial = {rem_ff, quo_ff[PW-1]};
      ge    = trial >= {1'b0, dsr_ff};
      diff  = trial - {1'b0, dsr_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // dividend bits leave at the top while quotient bits enter at the bottom
         rem_in = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
         quo_in = {quo_ff[PW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(PW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = nssc_pkg::OUT_W'(quo_ff);
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: design/nssc_seq.sv
// span sequencer: walks the pixels, launches divides and holds the result word
`timescale 1ns / 1ps

module nssc_seq #(
   parameter int MAX_SPAN   = nssc_pkg::MAX_SPAN_DEF,
   parameter int COORD_BITS = nssc_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [nssc_pkg::COORD_IN_W-1:0] span_x,
   input  logic [nssc_pkg::COORD_IN_W-1:0] span_y,
   input  logic [nssc_pkg::LEN_W-1:0]      span_length,
   input  logic [nssc_pkg::COORD_IN_W-1:0] origin_x,
   input  logic [nssc_pkg::COORD_IN_W-1:0] origin_y,
   input  logic [COORD_BITS-1:0]           start_x,
   input  logic [COORD_BITS-1:0]           start_y,
   input  logic [COORD_BITS-1:0]           dest_w,
   input  logic [COORD_BITS-1:0]           dest_h,
   input  logic [COORD_BITS-1:0]           src_w,
   input  logic [COORD_BITS-1:0]           src_h,
   output logic                            div_start,
   output logic [2*COORD_BITS:0]           div_dividend,
   output logic [COORD_BITS-1:0]           div_divisor,
   input  logic [nssc_pkg::OUT_W-1:0]      div_quotient,
   input  nssc_pkg::div_stat_type          div_stat,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [nssc_pkg::OUT_W-1:0]      src_col,
   output logic [nssc_pkg::OUT_W-1:0]      src_row,
   output logic                            inside_res,
   output logic                            last
);

   localparam int PW = 2 * COORD_BITS + 1;
   localparam int LW = $clog2(MAX_SPAN + 1);
   localparam int XW = nssc_pkg::XW;
   localparam int YW = nssc_pkg::COORD_IN_W + 1;

   nssc_pkg::seq_state_type state_ff, state_in;

   logic [XW-1:0]             cx_ff, cx_in;
   logic [COORD_BITS-1:0]     y_idx_ff, y_idx_in;
   logic                      row_in_ff, row_in_in;
   logic [LW-1:0]             remain_ff, remain_in;
   logic [nssc_pkg::OUT_W-1:0] row_q_ff, row_q_in;
   logic [nssc_pkg::OUT_W-1:0] col_q_ff, col_q_in;
   logic                      px_in_ff, px_in_in;
   logic                      valid_ff, valid_in;
   logic [nssc_pkg::OUT_W-1:0] col_out_ff, col_out_in;
   logic [nssc_pkg::OUT_W-1:0] row_out_ff, row_out_in;
   logic                      inside_ff, inside_in;
   logic                      last_ff, last_in;

   logic                      accept;
   logic [XW-1:0]             x_calc;
   logic [YW-1:0]             y_calc;
   logic                      row_hit;
   logic [LW-1:0]             len_calc;
   logic                      px_hit;
   logic                      out_free;
   logic                      row_sel;
   logic [COORD_BITS-1:0]     idx;
   logic [COORD_BITS-1:0]     base;
   logic [COORD_BITS-1:0]     scale;
   logic [COORD_BITS:0]       sum;

   always_comb begin
      accept   = req_tvalid && req_tready;
      x_calc   = XW'($signed(span_x)) - XW'($signed(origin_x));
      y_calc   = YW'($signed(span_y)) - YW'($signed(origin_y));
      row_hit  = !y_calc[YW-1] &&
                 (y_calc[YW-2:0] < nssc_pkg::COORD_IN_W'(dest_h));
      len_calc = (32'(span_length) > MAX_SPAN) ? LW'(MAX_SPAN) : LW'(span_length);
      px_hit   = row_in_ff && !cx_ff[XW-1] && (cx_ff < XW'(dest_w));
      out_free = !valid_ff || rsp_tready;

      // one multiplier shared by row and column, divider takes the product
      row_sel      = (state_ff == nssc_pkg::ST_ROW_GO);
      idx          = row_sel ? y_idx_ff : cx_ff[COORD_BITS-1:0];
      base         = row_sel ? start_y : start_x;
      scale        = row_sel ? src_h : src_w;
      sum          = {1'b0, idx} + {1'b0, base};
      div_dividend = PW'(sum) * PW'(scale);
      div_divisor  = row_sel ? dest_h : dest_w;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nssc_pkg::ST_IDLE: begin
            if (accept && (len_calc != '0)) begin
               state_in = row_hit ? nssc_pkg::ST_ROW_GO : nssc_pkg::ST_PIX;
            end
         end
         nssc_pkg::ST_ROW_GO: begin
            state_in = nssc_pkg::ST_ROW_WAIT;
         end
         nssc_pkg::ST_ROW_WAIT: begin
            if (div_stat.done) begin
               state_in = nssc_pkg::ST_PIX;
            end
         end
         nssc_pkg::ST_PIX: begin
            state_in = px_hit ? nssc_pkg::ST_COL_WAIT : nssc_pkg::ST_EMIT;
         end
         nssc_pkg::ST_COL_WAIT: begin
            if (div_stat.done) begin
               state_in = nssc_pkg::ST_EMIT;
            end
         end
         nssc_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = (remain_ff == LW'(1)) ? nssc_pkg::ST_IDLE : nssc_pkg::ST_PIX;
            end
         end
         default: begin
            state_in = nssc_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      cx_in      = cx_ff;
      y_idx_in   = y_idx_ff;
      row_in_in  = row_in_ff;
      remain_in  = remain_ff;
      row_q_in   = row_q_ff;
      col_q_in   = col_q_ff;
      px_in_in   = px_in_ff;
      valid_in   = rsp_tready ? 1'b0 : valid_ff;
      col_out_in = col_out_ff;
      row_out_in = row_out_ff;
      inside_in  = inside_ff;
      last_in    = last_ff;
      unique case (state_ff)
         nssc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               cx_in     = x_calc;
               y_idx_in  = y_calc[COORD_BITS-1:0];
               row_in_in = row_hit;
               remain_in = len_calc;
            end
         end
         nssc_pkg::ST_ROW_GO: begin
            div_start = 1'b1;
         end
         nssc_pkg::ST_ROW_WAIT: begin
            if (div_stat.done) begin
               row_q_in = div_quotient;
            end
         end
         nssc_pkg::ST_PIX: begin
            px_in_in  = px_hit;
            div_start = px_hit;
         end
         nssc_pkg::ST_COL_WAIT: begin
            if (div_stat.done) begin
               col_q_in = div_quotient;
            end
         end
         nssc_pkg::ST_EMIT: begin
            if (out_free) begin
               valid_in   = 1'b1;
               col_out_in = px_in_ff ? col_q_ff : '0;
               row_out_in = px_in_ff ? row_q_ff : '0;
               inside_in  = px_in_ff;
               last_in    = (remain_ff == LW'(1));
               remain_in  = remain_ff - 1'b1;
               cx_in      = cx_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nssc_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      cx_ff      <= cx_in;
      y_idx_ff   <= y_idx_in;
      row_in_ff  <= row_in_in;
      remain_ff  <= remain_in;
      row_q_ff   <= row_q_in;
      col_q_ff   <= col_q_in;
      px_in_ff   <= px_in_in;
      col_out_ff <= col_out_in;
      row_out_ff <= row_out_in;
      inside_ff  <= inside_in;
      last_ff    <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign src_col    = col_out_ff;
   assign src_row    = row_out_ff;
   assign inside_res = inside_ff;
   assign last       = last_ff;

endmodule

FILE: design/nearest_scale_span_coords.sv
// top level: register file, span sequencer and serial divider
`timescale 1ns / 1ps

// Nearest-neighbour scaled span coordinates. A request word gives a span
// (x, row, length); the block returns one word per pixel, in order, holding
// the source column and row ((index + start) * src / dest) and an inside flag,
// with tlast on the final pixel. Pixels outside the destination rectangle give
// inside = 0 and zero coordinates. Lengths above MAX_SPAN are cut to MAX_SPAN;
// a zero length gives no words. Spans are handled one at a time. The cost is
// set by the bit-serial divider, which produces one quotient bit per cycle: a
// span whose row is inside runs one divide for the row, then one divide for
// each inside pixel, while outside pixels need no divide; a stalled result
// side adds its stall to the pixel waiting to leave. The user must write the
// registers through the csr port only while no span is in progress; the block
// itself does not enforce it.

module nearest_scale_span_coords #(
   parameter int MAX_SPAN   = nssc_pkg::MAX_SPAN_DEF,
   parameter int COORD_BITS = nssc_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // span_x, span_y, span_length, zero pad
   input  logic [nssc_pkg::REQ_W-1:0]      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // src_col, src_row, zero pad
   output logic [nssc_pkg::RSP_W-1:0]      rsp_tdata,
   // inside_res
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [nssc_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [nssc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int OW = nssc_pkg::OUT_W;
   localparam int CI = nssc_pkg::COORD_IN_W;

   logic [CI-1:0]         origin_x_ff, origin_x_in;
   logic [CI-1:0]         origin_y_ff, origin_y_in;
   logic [COORD_BITS-1:0] start_x_ff, start_x_in;
   logic [COORD_BITS-1:0] start_y_ff, start_y_in;
   logic [COORD_BITS-1:0] dest_w_ff, dest_w_in;
   logic [COORD_BITS-1:0] dest_h_ff, dest_h_in;
   logic [COORD_BITS-1:0] src_w_ff, src_w_in;
   logic [COORD_BITS-1:0] src_h_ff, src_h_in;

   logic                  div_start;
   logic [2*COORD_BITS:0] div_dividend;
   logic [COORD_BITS-1:0] div_divisor;
   logic [OW-1:0]         div_quotient;
   nssc_pkg::div_stat_type div_stat;

   logic [OW-1:0]         src_col;
   logic [OW-1:0]         src_row;

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      start_x_in  = start_x_ff;
      start_y_in  = start_y_ff;
      dest_w_in   = dest_w_ff;
      dest_h_in   = dest_h_ff;
      src_w_in    = src_w_ff;
      src_h_in    = src_h_ff;
      if (csr_we) begin
         unique case (nssc_pkg::csr_idx_type'(csr_addr))
            nssc_pkg::CSR_ORIGIN_X: origin_x_in = csr_wdata;
            nssc_pkg::CSR_ORIGIN_Y: origin_y_in = csr_wdata;
            nssc_pkg::CSR_START_X:  start_x_in  = csr_wdata[COORD_BITS-1:0];
            nssc_pkg::CSR_START_Y:  start_y_in  = csr_wdata[COORD_BITS-1:0];
            nssc_pkg::CSR_DEST_W:   dest_w_in   = csr_wdata[COORD_BITS-1:0];
            nssc_pkg::CSR_DEST_H:   dest_h_in   = csr_wdata[COORD_BITS-1:0];
            nssc_pkg::CSR_SRC_W:    src_w_in    = csr_wdata[COORD_BITS-1:0];
            nssc_pkg::CSR_SRC_H:    src_h_in    = csr_wdata[COORD_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         start_x_ff  <= '0;
         start_y_ff  <= '0;
         dest_w_ff   <= COORD_BITS'(1);
         dest_h_ff   <= COORD_BITS'(1);
         src_w_ff    <= COORD_BITS'(1);
         src_h_ff    <= COORD_BITS'(1);
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         start_x_ff  <= start_x_in;
         start_y_ff  <= start_y_in;
         dest_w_ff   <= dest_w_in;
         dest_h_ff   <= dest_h_in;
         src_w_ff    <= src_w_in;
         src_h_ff    <= src_h_in;
      end
   end

   nssc_seq #(
      .MAX_SPAN   (MAX_SPAN),
      .COORD_BITS (COORD_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .span_x       (req_tdata[CI-1:0]),
      .span_y       (req_tdata[2*CI-1:CI]),
      .span_length  (req_tdata[2*CI+nssc_pkg::LEN_W-1:2*CI]),
      .origin_x     (origin_x_ff),
      .origin_y     (origin_y_ff),
      .start_x      (start_x_ff),
      .start_y      (start_y_ff),
      .dest_w       (dest_w_ff),
      .dest_h       (dest_h_ff),
      .src_w        (src_w_ff),
      .src_h        (src_h_ff),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_quotient (div_quotient),
      .div_stat     (div_stat),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .src_col      (src_col),
      .src_row      (src_row),
      .inside_res   (rsp_tuser),
      .last         (rsp_tlast)
   );

   nssc_div #(
      .COORD_BITS (COORD_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   assign rsp_tdata = {(nssc_pkg::RSP_W - 2*OW)'(0), src_row, src_col};

`ifndef SYNTHESIS
   // a divide is never launched on top of one still running
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   // pixels outside the rectangle carry zero coordinates
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[2*OW-1:0] == '0))
      else $error("outside pixel with nonzero coordinates");

   // a span of nonzero length keeps the request side closed next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tdata[2*CI+nssc_pkg::LEN_W-1:2*CI] != '0))
      |=> !req_tready)
      else $error("request taken while a span is in progress");
`endif

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the nearest scale span coordinate generator
`timescale 1ns / 1ps

module testbench;

   localparam int SPAN_CAP      = 64;
   localparam int SETTLE_CYCLES = 64;
   localparam int IDLE_LIMIT    = 4000;
   localparam int PRINT_CAP     = 100;

   typedef struct packed {
      logic [nssc_pkg::OUT_W-1:0] col;
      logic [nssc_pkg::OUT_W-1:0] row;
      logic                       in_rect;
      logic                       last;
   } pixel_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // span_x, span_y, span_length, zero pad
   logic [nssc_pkg::REQ_W-1:0]      req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // src_col, src_row, zero pad
   logic [nssc_pkg::RSP_W-1:0]      rsp_tdata;
   // inside_res
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_we     = 1'b0;
   logic [nssc_pkg::CSR_IDX_W-1:0]  csr_addr   = nssc_pkg::CSR_ORIGIN_X;
   logic [nssc_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   // register copies held by the predictor
   logic signed [15:0] org_x = '0;
   logic signed [15:0] org_y = '0;
   logic [11:0]        st_x  = '0;
   logic [11:0]        st_y  = '0;
   logic [11:0]        dst_w = 12'd1;
   logic [11:0]        dst_h = 12'd1;
   logic [11:0]        sr_w  = 12'd1;
   logic [11:0]        sr_h  = 12'd1;

   pixel_type pending_pixels[$];
   int        error_count   = 0;
   int        idle_cycles   = 0;
   int        stall_left    = 0;
   bit        gaps_enabled  = 1'b1;

   nearest_scale_span_coords dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic flag_mismatch(string msg);
      if (error_count < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // mostly short pauses, now and then a long one
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_enabled) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic predict_span_pixels(logic [15:0] sx, logic [15:0] sy, logic [6:0] slen);
      int        rel_x;
      int        rel_y;
      int        count;
      int        cx;
      bit        row_in;
      bit        px_in;
      longint    row_q;
      longint    col_q;
      pixel_type p;
      rel_x  = int'($signed(sx)) - int'(org_x);
      rel_y  = int'($signed(sy)) - int'(org_y);
      count  = (int'(slen) > SPAN_CAP) ? SPAN_CAP : int'(slen);
      row_in = (rel_y >= 0) && (rel_y < int'(dst_h));
      row_q  = 0;
      if (row_in) begin
         row_q = ((longint'(rel_y) + longint'(st_y)) * longint'(sr_h)) / longint'(dst_h);
      end
      for (int i = 0; i < count; i++) begin
         cx    = rel_x + i;
         px_in = row_in && (cx >= 0) && (cx < int'(dst_w));
         p     = '0;
         if (px_in) begin
            col_q     = ((longint'(cx) + longint'(st_x)) * longint'(sr_w)) / longint'(dst_w);
            p.col     = col_q[nssc_pkg::OUT_W-1:0];
            p.row     = row_q[nssc_pkg::OUT_W-1:0];
            p.in_rect = 1'b1;
         end
         p.last = (i == count - 1);
         pending_pixels.push_back(p);
      end
   endtask

   task automatic send_span(logic [15:0] sx, logic [15:0] sy, logic [6:0] slen);
      int gap;
      req_tdata  <= {1'b0, slen, sy, sx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_span_pixels(sx, sy, slen);
      gap = pick_pause();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // a zero-length span leaves no word behind, so allow it time to finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(logic [15:0] ox, logic [15:0] oy, logic [15:0] sx,
                               logic [15:0] sy, logic [15:0] dw, logic [15:0] dh,
                               logic [15:0] sw, logic [15:0] sh);
      logic [15:0]           vals [8];
      nssc_pkg::csr_idx_type idx;
      wait_idle();
      vals = '{ox, oy, sx, sy, dw, dh, sw, sh};
      idx  = nssc_pkg::CSR_ORIGIN_X;
      repeat (8) begin
         csr_we    <= 1'b1;
         csr_addr  <= idx;
         csr_wdata <= vals[idx];
         case (idx)
            nssc_pkg::CSR_ORIGIN_X: org_x = vals[idx];
            nssc_pkg::CSR_ORIGIN_Y: org_y = vals[idx];
            nssc_pkg::CSR_START_X:  st_x  = vals[idx][11:0];
            nssc_pkg::CSR_START_Y:  st_y  = vals[idx][11:0];
            nssc_pkg::CSR_DEST_W:   dst_w = vals[idx][11:0];
            nssc_pkg::CSR_DEST_H:   dst_h = vals[idx][11:0];
            nssc_pkg::CSR_SRC_W:    sr_w  = vals[idx][11:0];
            nssc_pkg::CSR_SRC_H:    sr_h  = vals[idx][11:0];
            default: ;
         endcase
         @(posedge clock);
         idx = idx.next();
      end
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_span(16'd0, 16'd0, 7'd1);
      send_span(16'hFFFF, 16'd0, 7'd3);
      send_span(16'd0, 16'd1, 7'd2);
      send_span(16'd0, 16'd0, 7'd0);
      send_span(16'd0, 16'hFFFF, 7'd1);
   endtask

   task automatic test_origin_extremes();
      // most negative x origin, most positive y origin, everything else at maximum
      program_regs(16'h8000, 16'h7FFF, 16'h0FFF, 16'h0FFF,
                   16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF);
      send_span(16'h8000, 16'h7FFF, 7'd64);
      send_span(16'h8000 + 16'd4030, 16'h7FFF, 7'd127);
      send_span(16'h7FFF, 16'h7FFF, 7'd65);
      send_span(16'h8000, 16'h8000, 7'd5);
      // the opposite corner: far edge of the rectangle gives the widest quotients
      program_regs(16'h7FFF, 16'h8000, 16'h0FFF, 16'h0FFF,
                   16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF);
      send_span(16'h7FFF, 16'h8000 + 16'd4094, 7'd1);
      send_span(16'h7FF0, 16'h8000, 7'd20);
      send_span(16'h7FFF, 16'h8000 + 16'd4095, 7'd3);
   endtask

   task automatic test_zero_destination();
      // upper bits are dropped, so these land on a zero width and a full height
      program_regs(16'd0, 16'd0, 16'hF005, 16'hA003, 16'h1000, 16'hFFFF, 16'h5007, 16'hF009);
      send_span(16'd0, 16'd0, 7'd4);
      send_span(16'hFFFE, 16'd10, 7'd6);
      program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd17, 16'hE000, 16'd3, 16'd3);
      send_span(16'd0, 16'd0, 7'd5);
      send_span(16'd2, 16'hFFFF, 7'd8);
   endtask

   task automatic test_random_spans(int items, bit with_gaps);
      int          rel_x;
      int          rel_y;
      int          r;
      logic [15:0] sx;
      logic [15:0] sy;
      logic [6:0]  slen;
      gaps_enabled = with_gaps;
      repeat (items) begin
         if ($urandom_range(0, 99) < 80) begin
            rel_y = int'($urandom_range(0, int'(dst_h) + 1)) - 1;
            rel_x = int'($urandom_range(0, int'(dst_w) + 60)) - 50;
            sx    = 16'(int'(org_x) + rel_x);
            sy    = 16'(int'(org_y) + rel_y);
         end else begin
            sx = 16'($urandom_range(0, 65535));
            sy = 16'($urandom_range(0, 65535));
         end
         r = $urandom_range(0, 99);
         if (r < 80)      slen = 7'($urandom_range(1, 12));
         else if (r < 93) slen = 7'($urandom_range(13, 64));
         else if (r < 96) slen = 7'd0;
         else             slen = 7'($urandom_range(65, 127));
         send_span(sx, sy, slen);
      end
      gaps_enabled = 1'b1;
   endtask

   function automatic logic [15:0] rand_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return {4'($urandom_range(0, 15)), 12'($urandom_range(1, 120))};
      if (r < 92) return {4'($urandom_range(0, 15)), 12'($urandom_range(1, 4095))};
      return {4'($urandom_range(0, 15)), 12'd0};
   endfunction

   function automatic logic [15:0] rand_start();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return {4'($urandom_range(0, 15)), 12'd0};
      if (r < 45) return {4'($urandom_range(0, 15)), 12'hFFF};
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] rand_origin();
      if ($urandom_range(0, 1)) return 16'($urandom_range(0, 65535));
      return 16'(int'($urandom_range(0, 400)) - 200);
   endfunction

   task automatic test_random_settings(int phases, int items);
      repeat (phases) begin
         program_regs(rand_origin(), rand_origin(), rand_start(), rand_start(),
                      rand_size(), rand_size(),
                      {4'($urandom_range(0, 15)), 12'($urandom_range(1, 4095))},
                      {4'($urandom_range(0, 15)), 12'($urandom_range(1, 4095))});
         test_random_spans(items, 1'b1);
      end
   endtask

   task automatic test_full_throughput();
      program_regs(16'd5, 16'hFFFB, 16'd3, 16'd7, 16'd40, 16'd30, 16'd13, 16'd90);
      test_random_spans(40, 1'b0);
   endtask

   task automatic test_size_extremes();
      program_regs(16'd0, 16'd0, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF);
      test_random_spans(30, 1'b1);
      program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1);
      test_random_spans(25, 1'b1);
   endtask

   // receiving side: check each word and stall at random
   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               flag_mismatch($sformatf("word with no span pending, data %h", rsp_tdata));
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_tdata[nssc_pkg::OUT_W-1:0] !== want.col)
                  flag_mismatch($sformatf("src_col %0d, expected %0d",
                                          rsp_tdata[nssc_pkg::OUT_W-1:0], want.col));
               if (rsp_tdata[2*nssc_pkg::OUT_W-1:nssc_pkg::OUT_W] !== want.row)
                  flag_mismatch($sformatf("src_row %0d, expected %0d",
                                          rsp_tdata[2*nssc_pkg::OUT_W-1:nssc_pkg::OUT_W],
                                          want.row));
               if (rsp_tuser !== want.in_rect)
                  flag_mismatch($sformatf("inside %b, expected %b", rsp_tuser, want.in_rect));
               if (rsp_tlast !== want.last)
                  flag_mismatch($sformatf("tlast %b, expected %b", rsp_tlast, want.last));
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_pause();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_origin_extremes();
      test_zero_destination();
      test_size_extremes();
      test_random_settings(3, 40);
      test_full_throughput();
      test_random_settings(1, 40);
      wait_idle();
      if (pending_pixels.size() != 0) begin
         flag_mismatch($sformatf("%0d words never arrived", pending_pixels.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/nssc_pkg.sv
design/nssc_div.sv
design/nssc_seq.sv
design/nearest_scale_span_coords.sv
tb/testbench.sv
